### rtl/bbc_pkg.sv
package bbc_pkg;

  // Table size and the widths that follow from it.
  localparam int SLOTS   = 32;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int REF_W   = 8;
  localparam int STAMP_W = 32;
  localparam int OUT_SLOT_W = 5;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } status_t;

  // One slot as read from the table.
  typedef struct packed {
    logic               valid;
    logic [DEV_W-1:0]   dev;
    logic [BLK_W-1:0]   blk;
    logic [REF_W-1:0]   refc;
    logic [STAMP_W-1:0] stamp;
  } rd_t;

  // One write into the table. The count and stamp always travel together.
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  addr;
    logic               tag_en;
    logic [DEV_W-1:0]   dev;
    logic [BLK_W-1:0]   blk;
    logic [REF_W-1:0]   refc;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

  // Outcome of a lookup scan.
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  hit_idx;
    logic [REF_W-1:0]   hit_ref;
    logic [STAMP_W-1:0] hit_stamp;
    logic               found;
    logic [SLOT_W-1:0]  pick_idx;
    logic [STAMP_W-1:0] oldest;
  } pick_t;

  // Slot number as it appears on the result port: masked to five bits.
  function automatic logic [OUT_SLOT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+OUT_SLOT_W-1:0] ext;
    ext = (SLOT_W+OUT_SLOT_W)'(idx);
    return ext[OUT_SLOT_W-1:0];
  endfunction

endpackage

### rtl/bbc_store.sv
module bbc_store import bbc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] rd_addr,
  input  wr_t               wr,
  output rd_t               rd
);

  logic [DEV_W+BLK_W-1:0]   tag_mem [SLOTS];
  logic [REF_W+STAMP_W-1:0] cnt_mem [SLOTS];
  logic [SLOTS-1:0]         valid_r;
  logic [SLOTS-1:0]         touched_r;

  logic [DEV_W+BLK_W-1:0]   tag_q_r;
  logic [REF_W+STAMP_W-1:0] cnt_q_r;
  logic                     valid_q_r;
  logic                     touched_q_r;

  // Tag and count memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      cnt_mem[wr.addr] <= {wr.refc, wr.stamp};
      if (wr.tag_en) begin
        tag_mem[wr.addr] <= {wr.dev, wr.blk};
      end
    end
    tag_q_r <= tag_mem[rd_addr];
    cnt_q_r <= cnt_mem[rd_addr];
  end

  // Per-slot flags. A count entry that was never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      touched_r   <= '0;
      valid_q_r   <= 1'b0;
      touched_q_r <= 1'b0;
    end else begin
      if (wr.en) begin
        touched_r[wr.addr] <= 1'b1;
        if (wr.tag_en) begin
          valid_r[wr.addr] <= 1'b1;
        end
      end
      valid_q_r   <= valid_r[rd_addr];
      touched_q_r <= touched_r[rd_addr];
    end
  end

  // Read data with untouched entries shown at their reset value.
  always_comb begin
    rd.valid = valid_q_r;
    rd.dev   = tag_q_r[DEV_W+BLK_W-1:BLK_W];
    rd.blk   = tag_q_r[BLK_W-1:0];
    rd.refc  = touched_q_r ? cnt_q_r[REF_W+STAMP_W-1:STAMP_W] : '0;
    rd.stamp = touched_q_r ? cnt_q_r[STAMP_W-1:0] : '0;
  end

endmodule

### rtl/bbc_pick.sv
module bbc_pick import bbc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              en,
  input  logic [SLOT_W-1:0] idx,
  input  rd_t               rd,
  input  logic [DEV_W-1:0]  key_dev,
  input  logic [BLK_W-1:0]  key_blk,
  output pick_t             res
);

  pick_t res_r;
  pick_t res_nxt;
  logic  match;
  logic  older;

  // Shared compare unit: one slot per cycle against the key and the oldest stamp.
  assign match = rd.valid && (rd.dev == key_dev) && (rd.blk == key_blk);
  assign older = (rd.refc == '0) && (!res_r.found || (rd.stamp < res_r.oldest));

  always_comb begin
    res_nxt = res_r;
    if (clr) begin
      res_nxt.hit   = 1'b0;
      res_nxt.found = 1'b0;
    end else if (en) begin
      // First matching slot wins; later matches are ignored.
      if (match && !res_r.hit) begin
        res_nxt.hit       = 1'b1;
        res_nxt.hit_idx   = idx;
        res_nxt.hit_ref   = rd.refc;
        res_nxt.hit_stamp = rd.stamp;
      end
      // Strictly older wins, so ties stay with the lowest slot.
      if (older) begin
        res_nxt.found    = 1'b1;
        res_nxt.pick_idx = idx;
        res_nxt.oldest   = rd.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.hit   <= 1'b0;
      res_r.found <= 1'b0;
    end else begin
      res_r.hit   <= res_nxt.hit;
      res_r.found <= res_nxt.found;
    end
    res_r.hit_idx   <= res_nxt.hit_idx;
    res_r.hit_ref   <= res_nxt.hit_ref;
    res_r.hit_stamp <= res_nxt.hit_stamp;
    res_r.pick_idx  <= res_nxt.pick_idx;
    res_r.oldest    <= res_nxt.oldest;
  end

  assign res = res_r;

endmodule

### rtl/block_buffer_cache_lru.sv
// Buffer cache slot table with reference counts and least-recently-released
// replacement.
// Input channel: a command beat is taken at a rising edge where start is high
// and busy is low. in_op selects get, release, pin or unpin; a get uses
// in_dev and in_block, the others use in_slot, and a release stamps
// in_time_now when the count falls to zero.
// Result channel: one result beat per command, shown for exactly one cycle
// with out_strobe high. The receiver cannot stall, so nothing is held back.
// Timing: a get scans every slot through one shared compare unit, one slot
// per cycle from a registered memory read, then decides in S_GDEC and
// registers its result. Release, pin and unpin read one slot through the
// registered memory read, decide in S_ONE and register their result; a slot
// number outside the table is answered straight from S_IDLE. busy stays high
// until the result is in flight, so one command is worked on at a time.
// Reset clears the valid marks and counts at once; no clearing pass is needed
// and a command can be given in the first cycle after reset.
module block_buffer_cache_lru import bbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [DEV_W-1:0]      in_dev,
  input  logic [BLK_W-1:0]      in_block,
  input  logic [4:0]            in_slot,
  input  logic [STAMP_W-1:0]    in_time_now,
  output logic                  out_strobe,
  output logic [OUT_SLOT_W-1:0] out_slot_out,
  output logic                  out_hit,
  output logic                  out_need_fill,
  output logic [1:0]            out_status,
  output logic [REF_W-1:0]      out_refs_after
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GDEC,
    S_ONE
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);
  localparam logic [8:0]        SLOTS_9  = 9'(SLOTS);

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [DEV_W-1:0]      dev_r, dev_nxt;
  logic [BLK_W-1:0]      blk_r, blk_nxt;
  logic [STAMP_W-1:0]    now_r, now_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic                  strobe_r, strobe_nxt;
  logic [OUT_SLOT_W-1:0] slot_out_r, slot_out_nxt;
  logic                  hit_r, hit_nxt;
  logic                  fill_r, fill_nxt;
  status_t               status_r, status_nxt;
  logic [REF_W-1:0]      refs_r, refs_nxt;

  logic [SLOT_W-1:0] rd_addr;
  wr_t               wr;
  rd_t               rd;
  logic              pk_clr;
  logic              pk_en;
  pick_t             pk;
  logic [8:0]        slot9;
  logic [REF_W-1:0]  ref_dec;

  bbc_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  bbc_pick u_pick (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (pk_clr),
    .en      (pk_en),
    .idx     (idx_r),
    .rd      (rd),
    .key_dev (dev_r),
    .key_blk (blk_r),
    .res     (pk)
  );

  assign slot9   = 9'(in_slot);
  assign ref_dec = rd.refc - REF_W'(1);

  // Sequencer: command capture, slot scan, decision and write-back.
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    dev_nxt      = dev_r;
    blk_nxt      = blk_r;
    now_nxt      = now_r;
    idx_nxt      = idx_r;
    strobe_nxt   = 1'b0;
    slot_out_nxt = slot_out_r;
    hit_nxt      = hit_r;
    fill_nxt     = fill_r;
    status_nxt   = status_r;
    refs_nxt     = refs_r;
    rd_addr      = idx_r;
    wr           = '0;
    pk_clr       = 1'b0;
    pk_en        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = op_t'(in_op);
          dev_nxt = in_dev;
          blk_nxt = in_block;
          now_nxt = in_time_now;
          if (op_t'(in_op) == OP_GET) begin
            rd_addr   = '0;
            idx_nxt   = '0;
            pk_clr    = 1'b1;
            state_nxt = S_SCAN;
          end else if (slot9 < SLOTS_9) begin
            rd_addr   = slot9[SLOT_W-1:0];
            idx_nxt   = slot9[SLOT_W-1:0];
            state_nxt = S_ONE;
          end else begin
            // Slot beyond the table: answer at once, change nothing.
            strobe_nxt   = 1'b1;
            slot_out_nxt = '0;
            hit_nxt      = 1'b0;
            fill_nxt     = 1'b0;
            status_nxt   = ST_NOFREE;
            refs_nxt     = '0;
          end
        end
      end

      S_SCAN: begin
        // Data for slot idx_r is on the read port; fetch the next one.
        pk_en = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_GDEC;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
          rd_addr = idx_r + SLOT_W'(1);
        end
      end

      S_GDEC: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (pk.hit) begin
          slot_out_nxt = slot_to_out(pk.hit_idx);
          hit_nxt      = 1'b1;
          fill_nxt     = 1'b0;
          if (pk.hit_ref == REF_MAX) begin
            status_nxt = ST_OVER;
            refs_nxt   = REF_MAX;
          end else begin
            status_nxt = ST_OK;
            refs_nxt   = pk.hit_ref + REF_W'(1);
            wr.en      = 1'b1;
            wr.addr    = pk.hit_idx;
            wr.refc    = pk.hit_ref + REF_W'(1);
            wr.stamp   = pk.hit_stamp;
          end
        end else if (pk.found) begin
          // Reuse the oldest free slot and keep its stamp.
          slot_out_nxt = slot_to_out(pk.pick_idx);
          hit_nxt      = 1'b0;
          fill_nxt     = 1'b1;
          status_nxt   = ST_OK;
          refs_nxt     = REF_W'(1);
          wr.en        = 1'b1;
          wr.addr      = pk.pick_idx;
          wr.tag_en    = 1'b1;
          wr.dev       = dev_r;
          wr.blk       = blk_r;
          wr.refc      = REF_W'(1);
          wr.stamp     = pk.oldest;
        end else begin
          slot_out_nxt = '0;
          hit_nxt      = 1'b0;
          fill_nxt     = 1'b0;
          status_nxt   = ST_NOFREE;
          refs_nxt     = '0;
        end
      end

      S_ONE: begin
        strobe_nxt   = 1'b1;
        state_nxt    = S_IDLE;
        slot_out_nxt = slot_to_out(idx_r);
        hit_nxt      = 1'b0;
        fill_nxt     = 1'b0;
        wr.addr      = idx_r;
        wr.stamp     = rd.stamp;
        if (op_r == OP_PIN) begin
          if (rd.refc == REF_MAX) begin
            status_nxt = ST_OVER;
            refs_nxt   = REF_MAX;
          end else begin
            status_nxt = ST_OK;
            refs_nxt   = rd.refc + REF_W'(1);
            wr.en      = 1'b1;
            wr.refc    = rd.refc + REF_W'(1);
          end
        end else if (rd.refc == '0) begin
          status_nxt = ST_UNDER;
          refs_nxt   = '0;
        end else begin
          // Release or unpin; only a release that frees the slot stamps it.
          status_nxt = ST_OK;
          refs_nxt   = ref_dec;
          wr.en      = 1'b1;
          wr.refc    = ref_dec;
          if (op_r == OP_RELEASE && ref_dec == '0) begin
            wr.stamp = now_r;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
    op_r       <= op_nxt;
    dev_r      <= dev_nxt;
    blk_r      <= blk_nxt;
    now_r      <= now_nxt;
    idx_r      <= idx_nxt;
    slot_out_r <= slot_out_nxt;
    hit_r      <= hit_nxt;
    fill_r     <= fill_nxt;
    status_r   <= status_nxt;
    refs_r     <= refs_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = strobe_r;
  assign out_slot_out   = slot_out_r;
  assign out_hit        = hit_r;
  assign out_need_fill  = fill_r;
  assign out_status     = status_r;
  assign out_refs_after = refs_r;

endmodule

### dv/bbc_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels of the buffer cache, keeps its own
// copy of the slot table, and checks every result beat against the oldest
// outstanding prediction.
module bbc_checker import bbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [DEV_W-1:0]      in_dev,
  input  logic [BLK_W-1:0]      in_block,
  input  logic [4:0]            in_slot,
  input  logic [STAMP_W-1:0]    in_time_now,
  input  logic                  out_strobe,
  input  logic [OUT_SLOT_W-1:0] out_slot_out,
  input  logic                  out_hit,
  input  logic                  out_need_fill,
  input  logic [1:0]            out_status,
  input  logic [REF_W-1:0]      out_refs_after,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot;
    logic                  hit;
    logic                  fill;
    status_t               status;
    logic [REF_W-1:0]      refs;
  } cache_result_t;

  // Shadow copy of the slot table.
  logic [DEV_W-1:0]   shadow_dev   [SLOTS];
  logic [BLK_W-1:0]   shadow_blk   [SLOTS];
  logic [REF_W-1:0]   shadow_refs  [SLOTS];
  logic [STAMP_W-1:0] shadow_stamp [SLOTS];
  logic               shadow_valid [SLOTS];

  cache_result_t awaited_results[$];

  function automatic cache_result_t pack_result(input int idx, input logic h, input logic f,
                                                input status_t st, input logic [REF_W-1:0] r);
    cache_result_t res;
    res.slot   = OUT_SLOT_W'(idx);
    res.hit    = h;
    res.fill   = f;
    res.status = st;
    res.refs   = r;
    return res;
  endfunction

  // Applies one command beat to the shadow table and returns its outcome.
  function automatic cache_result_t apply_command(input op_t op, input logic [DEV_W-1:0] dev,
                                                  input logic [BLK_W-1:0] blk,
                                                  input logic [4:0] slot,
                                                  input logic [STAMP_W-1:0] now);
    int victim;
    logic [STAMP_W-1:0] oldest;
    int s;
    victim = -1;
    oldest = '0;
    s = int'(slot);
    if (op == OP_GET) begin
      // A cached tag wins, whatever its count.
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_valid[i] && shadow_dev[i] == dev && shadow_blk[i] == blk) begin
          if (shadow_refs[i] == REF_MAX) return pack_result(i, 1'b1, 1'b0, ST_OVER, REF_MAX);
          shadow_refs[i] = shadow_refs[i] + 1'b1;
          return pack_result(i, 1'b1, 1'b0, ST_OK, shadow_refs[i]);
        end
      end
      // Otherwise reuse the unreferenced slot released longest ago, lowest on a tie.
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_refs[i] == '0 && (victim < 0 || shadow_stamp[i] < oldest)) begin
          victim = i;
          oldest = shadow_stamp[i];
        end
      end
      if (victim < 0) return pack_result(0, 1'b0, 1'b0, ST_NOFREE, '0);
      shadow_dev[victim]   = dev;
      shadow_blk[victim]   = blk;
      shadow_refs[victim]  = REF_W'(1);
      shadow_valid[victim] = 1'b1;
      return pack_result(victim, 1'b0, 1'b1, ST_OK, REF_W'(1));
    end
    if (s >= SLOTS) return pack_result(0, 1'b0, 1'b0, ST_NOFREE, '0);
    if (op == OP_PIN) begin
      if (shadow_refs[s] == REF_MAX) return pack_result(s, 1'b0, 1'b0, ST_OVER, REF_MAX);
      shadow_refs[s] = shadow_refs[s] + 1'b1;
      return pack_result(s, 1'b0, 1'b0, ST_OK, shadow_refs[s]);
    end
    // Release and unpin count down; only the final release stamps the tick.
    if (shadow_refs[s] == '0) return pack_result(s, 1'b0, 1'b0, ST_UNDER, '0);
    shadow_refs[s] = shadow_refs[s] - 1'b1;
    if (op == OP_RELEASE && shadow_refs[s] == '0) shadow_stamp[s] = now;
    return pack_result(s, 1'b0, 1'b0, ST_OK, shadow_refs[s]);
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        shadow_dev[i]   = '0;
        shadow_blk[i]   = '0;
        shadow_refs[i]  = '0;
        shadow_stamp[i] = '0;
        shadow_valid[i] = 1'b0;
      end
      awaited_results.delete();
    end else begin
      // Result beat: compare against the oldest prediction.
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, slot_out %0d status %0d",
                   $time, out_slot_out, out_status);
        end else begin
          want = awaited_results.pop_front();
          check_field("slot_out", int'(want.slot), int'(out_slot_out));
          check_field("hit", int'(want.hit), int'(out_hit));
          check_field("need_fill", int'(want.fill), int'(out_need_fill));
          check_field("status", int'(want.status), int'(out_status));
          check_field("refs_after", int'(want.refs), int'(out_refs_after));
        end
      end
      // Command beat: predict its result.
      if (start && !busy) begin
        awaited_results.push_back(apply_command(op_t'(in_op), in_dev, in_block, in_slot,
                                                in_time_now));
      end
    end
    pending = awaited_results.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import bbc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_op;
  logic [DEV_W-1:0]      in_dev;
  logic [BLK_W-1:0]      in_block;
  logic [4:0]            in_slot;
  logic [STAMP_W-1:0]    in_time_now;
  logic                  out_strobe;
  logic [OUT_SLOT_W-1:0] out_slot_out;
  logic                  out_hit;
  logic                  out_need_fill;
  logic [1:0]            out_status;
  logic [REF_W-1:0]      out_refs_after;

  int                    errors;
  int                    pending;
  int                    idle_pct;
  int                    beats_sent;
  logic [STAMP_W-1:0]    tick;
  logic [BLK_W-1:0]      block_pool [8];
  logic [OUT_SLOT_W-1:0] last_slot;

  block_buffer_cache_lru DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_dev         (in_dev),
    .in_block       (in_block),
    .in_slot        (in_slot),
    .in_time_now    (in_time_now),
    .out_strobe     (out_strobe),
    .out_slot_out   (out_slot_out),
    .out_hit        (out_hit),
    .out_need_fill  (out_need_fill),
    .out_status     (out_status),
    .out_refs_after (out_refs_after)
  );

  bbc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_dev         (in_dev),
    .in_block       (in_block),
    .in_slot        (in_slot),
    .in_time_now    (in_time_now),
    .out_strobe     (out_strobe),
    .out_slot_out   (out_slot_out),
    .out_hit        (out_hit),
    .out_need_fill  (out_need_fill),
    .out_status     (out_status),
    .out_refs_after (out_refs_after),
    .errors         (errors),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("[block_buffer_cache_lru] ERROR");
    $finish;
  end

  // Remember the slot of the latest result so a sequence can aim at it.
  always @(posedge clk) begin
    if (out_strobe) last_slot <= out_slot_out;
  end

  // Mostly a slowly rising tick so stamps tie and order; sometimes a wild value.
  function automatic logic [STAMP_W-1:0] next_tick();
    if ($urandom_range(0, 15) == 0) tick = $urandom;
    else tick = tick + $urandom_range(0, 3);
    return tick;
  endfunction

  // Presents one command beat and waits for it to be taken.
  task automatic issue(input op_t op, input logic [DEV_W-1:0] dev, input logic [BLK_W-1:0] blk,
                       input logic [4:0] slot, input logic [STAMP_W-1:0] now);
    start       <= 1'b1;
    in_op       <= op;
    in_dev      <= dev;
    in_block    <= blk;
    in_slot     <= slot;
    in_time_now <= now;
    do @(posedge clk); while (busy);
    beats_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Mixed traffic over a small tag pool so gets hit as well as miss.
  task automatic run_mix(input int count);
    int pick;
    op_t op;
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      op   = (pick < 45) ? OP_GET : (pick < 70) ? OP_RELEASE : (pick < 85) ? OP_PIN : OP_UNPIN;
      dev  = ($urandom_range(0, 9) < 8) ? DEV_W'($urandom_range(0, 3)) : DEV_W'($urandom);
      blk  = ($urandom_range(0, 9) < 8) ? block_pool[$urandom_range(0, 7)] : $urandom;
      issue(op, dev, blk, 5'($urandom_range(0, 31)), next_tick());
    end
  endtask

  // Fresh tags until the table runs dry, then releases in shuffled order
  // so the replacement order follows the stamps.
  task automatic run_fill_drain();
    int order [32];
    int j;
    int tmp;
    repeat (SLOTS + 2) issue(OP_GET, DEV_W'($urandom), $urandom, 5'($urandom), next_tick());
    repeat (2) begin
      for (int i = 0; i < 32; i++) order[i] = i;
      for (int i = 31; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < 32; i++) begin
        issue(OP_RELEASE, DEV_W'($urandom), $urandom, 5'(order[i]), next_tick());
      end
    end
  endtask

  task automatic run_random_part(input int until_count);
    while (beats_sent < until_count) begin
      if ($urandom_range(0, 99) < 25) run_fill_drain();
      else run_mix($urandom_range(10, 40));
    end
  endtask

  // Drives one slot into saturation through get hits and a pin, then back
  // down through releases to zero and one unpin past it.
  task automatic run_saturate();
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic [4:0] target;
    dev = DEV_W'($urandom);
    blk = $urandom;
    repeat (REF_MAX + 2) issue(OP_GET, dev, blk, 5'($urandom), next_tick());
    drain();
    target = last_slot;
    issue(OP_PIN, DEV_W'($urandom), $urandom, target, next_tick());
    repeat (REF_MAX) issue(OP_RELEASE, DEV_W'($urandom), $urandom, target, next_tick());
    issue(OP_UNPIN, DEV_W'($urandom), $urandom, target, next_tick());
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_op       = OP_GET;
    in_dev      = '0;
    in_block    = '0;
    in_slot     = '0;
    in_time_now = '0;
    idle_pct    = 0;
    beats_sent  = 0;
    tick        = '0;
    block_pool[0] = '0;
    block_pool[1] = '1;
    for (int i = 2; i < 8; i++) block_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero tags after reset must miss, extremes of every field,
    // unpin to zero, underflow, final release stamping, and a hit on an
    // unreferenced but still valid slot.
    issue(OP_GET, 8'h00, 32'h0000_0000, 5'd0, 32'd0);
    issue(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    issue(OP_GET, 8'h00, 32'h0000_0000, 5'd0, 32'd0);
    issue(OP_PIN, 8'h00, 32'h0, 5'd31, 32'd0);
    issue(OP_UNPIN, 8'h00, 32'h0, 5'd31, 32'd7);
    issue(OP_UNPIN, 8'h00, 32'h0, 5'd31, 32'd7);
    issue(OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd1, 32'hFFFF_FFFF);
    issue(OP_RELEASE, 8'h00, 32'h0, 5'd1, 32'd3);
    issue(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'd4);
    issue(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'd5);
    issue(OP_GET, 8'hA5, 32'h5A5A_5A5A, 5'd0, 32'd6);
    issue(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd6);
    issue(OP_RELEASE, 8'h00, 32'h0, 5'd0, 32'd8);
    issue(OP_PIN, 8'h00, 32'h0, 5'd0, 32'd8);
    issue(OP_UNPIN, 8'h00, 32'h0, 5'd0, 32'd9);

    // Random traffic: sender gaps first light, then heavy, then none.
    idle_pct = 23;
    run_random_part(350);
    idle_pct = 51;
    run_random_part(650);
    idle_pct = 0;
    run_saturate();
    run_random_part(1100);

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[block_buffer_cache_lru] OK");
    end else begin
      $display("[block_buffer_cache_lru] ERROR");
    end
    $finish;
  end

endmodule
